// ===== sv/mcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_pkg
// Types, widths and reset constants for the multi-click button detector.
// ----------------------------------------------------------------------------
package mcbd_pkg;

    // default sizing
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int TIME_BITS_DEF   = 32;

    // field widths
    localparam int POS_W     = 16;
    localparam int BTN_W     = 3;
    localparam int CNT_W     = 8;
    localparam int MS_W      = 16;
    localparam int TS_W      = 32;
    localparam int CFG_IDX_W = 1;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = 2 * POS_W + BTN_W + 1 + TS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * POS_W + BTN_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // reset values
    localparam logic [MS_W-1:0]  CLICK_HOLD_RST  = 16'd300;
    localparam logic [MS_W-1:0]  RELEASE_GAP_RST = 16'd300;
    localparam logic [POS_W-1:0] POS_RST         = '1;
    localparam logic [CNT_W-1:0] CNT_MAX         = '1;

    // item kind carried on tuser
    typedef enum logic [0:0] {
        OP_POS    = 1'b0,
        OP_BUTTON = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLICK_HOLD  = 1'b0,
        CFG_RELEASE_GAP = 1'b1
    } t_cfg_reg;

endpackage

// ===== sv/multi_click_button_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_click_button_detector
// Pointer position and multi-click tracking for up to NUM_BUTTONS buttons.
// ----------------------------------------------------------------------------
// One item is taken on every clock while the result side keeps up; each item
// is held in the input register and its result in the event register, from
// which it is presented on the output stream. The rate is set by the
// per-button state update, which reads and writes the level, press count
// and edge timestamp of one button in one registered update so that the next
// item sees it. Position items and button samples that change nothing give no
// event. A press gives an event with count 0 at once; a held or released run
// of at least the configured time gives the number of presses in the sequence
// (saturating at 255). Every event carries the last stored position.
// Timestamps wrap modulo 2^TIME_BITS. Configuration writes are taken in any
// cycle and are meant for idle periods.
module multi_click_button_detector #(
    parameter int NUM_BUTTONS = mcbd_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = mcbd_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, button, level, time_ms (zero padded)
    input  logic [mcbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [0:0]                        s_axis_tuser,
    // events
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_x, event_y, event_button, event_count (zero padded)
    output logic [mcbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcbd_pkg::MS_W-1:0]         i_cfg_data
);

    localparam int POS_W = mcbd_pkg::POS_W;
    localparam int BTN_W = mcbd_pkg::BTN_W;
    localparam int CNT_W = mcbd_pkg::CNT_W;
    localparam int MS_W  = mcbd_pkg::MS_W;
    localparam int TS_W  = mcbd_pkg::TS_W;
    localparam int PAD_W = mcbd_pkg::OUT_TDATA_W - mcbd_pkg::OUT_FIELDS_W;

    // configuration registers
    logic [MS_W-1:0] r_click_hold;
    logic [MS_W-1:0] r_release_gap;

    // input register
    logic                 r_in_valid;
    mcbd_pkg::t_op        r_op;
    logic [POS_W-1:0]     r_pos_x;
    logic [POS_W-1:0]     r_pos_y;
    logic [BTN_W-1:0]     r_button;
    logic                 r_level;
    logic [TS_W-1:0]      r_time;

    // tracked state
    logic [POS_W-1:0]     r_cur_x;
    logic [POS_W-1:0]     r_cur_y;
    logic                 r_down  [NUM_BUTTONS];
    logic [CNT_W-1:0]     r_tally [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_edge  [NUM_BUTTONS];

    // next state per button
    logic                 n_down  [NUM_BUTTONS];
    logic [CNT_W-1:0]     n_tally [NUM_BUTTONS];
    logic [TIME_BITS-1:0] n_edge  [NUM_BUTTONS];

    // event register
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_ev_x;
    logic [POS_W-1:0]     r_ev_y;
    logic [BTN_W-1:0]     r_ev_button;
    logic [CNT_W-1:0]     r_ev_count;

    // compute stage
    logic                 fire;
    logic                 sel_any;
    logic                 sel_down;
    logic [CNT_W-1:0]     sel_tally;
    logic [TIME_BITS-1:0] sel_edge;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] limit;
    logic                 level_change;
    logic                 press;
    logic                 report;

    // handshakes
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_hold  <= mcbd_pkg::CLICK_HOLD_RST;
            r_release_gap <= mcbd_pkg::RELEASE_GAP_RST;
        end else if (i_cfg_valid) begin
            unique case (mcbd_pkg::t_cfg_reg'(i_cfg_index))
                mcbd_pkg::CFG_CLICK_HOLD:  r_click_hold  <= i_cfg_data;
                mcbd_pkg::CFG_RELEASE_GAP: r_release_gap <= i_cfg_data;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= mcbd_pkg::t_op'(s_axis_tuser[0]);
            r_pos_x  <= s_axis_tdata[POS_W-1:0];
            r_pos_y  <= s_axis_tdata[2*POS_W-1:POS_W];
            r_button <= s_axis_tdata[2*POS_W+BTN_W-1:2*POS_W];
            r_level  <= s_axis_tdata[2*POS_W+BTN_W];
            r_time   <= s_axis_tdata[2*POS_W+BTN_W+TS_W:2*POS_W+BTN_W+1];
        end
    end

    // timestamp kept to TIME_BITS bits
    assign now = TIME_BITS'(r_time);

    // pick the sampled button's state
    always_comb begin
        sel_any   = 1'b0;
        sel_down  = 1'b0;
        sel_tally = '0;
        sel_edge  = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (r_op == mcbd_pkg::OP_BUTTON && int'(r_button) == b) begin
                sel_any   = 1'b1;
                sel_down  = r_down[b];
                sel_tally = r_tally[b];
                sel_edge  = r_edge[b];
            end
        end
    end

    // edge and timeout decisions
    assign elapsed      = now - sel_edge;
    assign limit        = sel_down ? TIME_BITS'(r_click_hold) : TIME_BITS'(r_release_gap);
    assign level_change = sel_any && (r_level != sel_down);
    assign press        = level_change && r_level;
    assign report       = sel_any && !level_change && (sel_tally != '0) && (elapsed >= limit);

    // next state per button
    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_down[b]  = r_down[b];
            n_tally[b] = r_tally[b];
            n_edge[b]  = r_edge[b];
            if (r_op == mcbd_pkg::OP_BUTTON && int'(r_button) == b) begin
                if (level_change) begin
                    n_down[b] = r_level;
                    n_edge[b] = now;
                    if (r_level && r_tally[b] != mcbd_pkg::CNT_MAX) begin
                        n_tally[b] = r_tally[b] + CNT_W'(1);
                    end
                end else if (report) begin
                    n_tally[b] = '0;
                end
            end
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= mcbd_pkg::POS_RST;
            r_cur_y <= mcbd_pkg::POS_RST;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_down[b]  <= 1'b0;
                r_tally[b] <= '0;
                r_edge[b]  <= '0;
            end
        end else if (fire) begin
            if (r_op == mcbd_pkg::OP_POS) begin
                r_cur_x <= r_pos_x;
                r_cur_y <= r_pos_y;
            end
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_down[b]  <= n_down[b];
                r_tally[b] <= n_tally[b];
                r_edge[b]  <= n_edge[b];
            end
        end
    end

    // event register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= press || report;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // event register payload
    always_ff @(posedge i_clk) begin
        if (fire && (press || report)) begin
            r_ev_x      <= r_cur_x;
            r_ev_y      <= r_cur_y;
            r_ev_button <= r_button;
            r_ev_count  <= press ? '0 : sel_tally;
        end
    end

    // output transfer
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_ev_count, r_ev_button, r_ev_y, r_ev_x};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-click button detector.
// ----------------------------------------------------------------------------
// Position updates and button level samples are queued by a stimulus process
// and fed to the input stream by a clocked driver. The driver tracks the
// pointer, levels, press counts and edge timestamps of every accepted
// transfer and queues the events that should follow. A clocked monitor
// compares each event transfer with the oldest queued event. The run starts
// with hand-picked cases at the reset setting, then goes through several
// hold and release settings with mostly well-formed click runs, some noise,
// a press-count saturation burst and timestamps across the wrap. Both stream
// sides stall at random rates that change between phases.
module testbench;

    localparam int NBTN         = mcbd_pkg::NUM_BUTTONS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 100;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam int POS_W        = mcbd_pkg::POS_W;
    localparam int BTN_W        = mcbd_pkg::BTN_W;
    localparam int CNT_W        = mcbd_pkg::CNT_W;
    localparam int MS_W         = mcbd_pkg::MS_W;
    localparam int TS_W         = mcbd_pkg::TS_W;
    localparam int CFG_IDX_W    = mcbd_pkg::CFG_IDX_W;
    localparam int IN_FIELDS_W  = mcbd_pkg::IN_FIELDS_W;
    localparam int IN_TDATA_W   = mcbd_pkg::IN_TDATA_W;
    localparam int OUT_FIELDS_W = mcbd_pkg::OUT_FIELDS_W;
    localparam int OUT_TDATA_W  = mcbd_pkg::OUT_TDATA_W;

    // input item, pos_x in the lowest bits as on tdata, kind on top
    typedef struct packed {
        mcbd_pkg::t_op    op;
        logic [TS_W-1:0]  time_ms;
        logic             level;
        logic [BTN_W-1:0] button;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } t_button_sample;

    // event, laid out as on the result tdata
    typedef struct packed {
        logic [CNT_W-1:0] ev_count;
        logic [BTN_W-1:0] ev_button;
        logic [POS_W-1:0] ev_y;
        logic [POS_W-1:0] ev_x;
    } t_click_event;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // pos_x, pos_y, button, level, time_ms (zero padded)
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // operation
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // event_x, event_y, event_button, event_count (zero padded)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = mcbd_pkg::CFG_CLICK_HOLD;
    logic [MS_W-1:0]        i_cfg_data = '0;

    // items waiting for the driver and events waiting for the monitor
    t_button_sample pending_samples[$];
    t_click_event   expected_clicks[$];
    t_button_sample drive_item;

    // tracked block state
    logic [POS_W-1:0] trk_x, trk_y;
    logic             trk_down  [NBTN];
    logic [CNT_W-1:0] trk_tally [NBTN];
    logic [TS_W-1:0]  trk_edge  [NBTN];
    logic [MS_W-1:0]  hold_lim, gap_lim;

    // stimulus-side view
    logic [TS_W-1:0]  gen_now = '0;
    logic             gen_down [NBTN];
    logic [MS_W-1:0]  hold_set = mcbd_pkg::CLICK_HOLD_RST;
    logic [MS_W-1:0]  gap_set  = mcbd_pkg::RELEASE_GAP_RST;
    int               gen_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_accepted = 0;
    int events_checked = 0;
    int cfg_writes = 0;
    int settings_used = 1;
    int errors = 0;

    multi_click_button_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // update tracked state for one accepted item and queue its event
    task automatic detect_click(input t_button_sample s);
        t_click_event    ev;
        logic [TS_W-1:0] span;
        logic [MS_W-1:0] lim;
        int              b;
        b = s.button;
        ev.ev_x = trk_x;
        ev.ev_y = trk_y;
        ev.ev_button = s.button;
        ev.ev_count = '0;
        if (s.op == mcbd_pkg::OP_POS) begin
            trk_x = s.pos_x;
            trk_y = s.pos_y;
        end else if (b < NBTN) begin
            if (s.level != trk_down[b]) begin
                // level change: remember it, a press is announced at once
                trk_down[b] = s.level;
                trk_edge[b] = s.time_ms;
                if (s.level) begin
                    expected_clicks.push_back(ev);
                    if (trk_tally[b] != mcbd_pkg::CNT_MAX)
                        trk_tally[b] = trk_tally[b] + CNT_W'(1);
                end
            end else if (trk_tally[b] != '0) begin
                // same level with presses pending: has the run lasted long enough
                span = s.time_ms - trk_edge[b];
                lim = trk_down[b] ? hold_lim : gap_lim;
                if (span >= {{(TS_W-MS_W){1'b0}}, lim}) begin
                    ev.ev_count = trk_tally[b];
                    expected_clicks.push_back(ev);
                    trk_tally[b] = '0;
                end
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_button_sample nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            trk_x = mcbd_pkg::POS_RST;
            trk_y = mcbd_pkg::POS_RST;
            hold_lim = mcbd_pkg::CLICK_HOLD_RST;
            gap_lim = mcbd_pkg::RELEASE_GAP_RST;
            for (int k = 0; k < NBTN; k++) begin
                trk_down[k] = 1'b0;
                trk_tally[k] = '0;
                trk_edge[k] = '0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                detect_click(drive_item);
                items_accepted++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the item until the transfer
            end else if (pending_samples.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_samples.pop_front();
                drive_item <= nxt;
                s_axis_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, nxt[IN_FIELDS_W-1:0]};
                s_axis_tuser <= nxt.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // event monitor
    always @(posedge i_clk) begin
        t_click_event got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (expected_clicks.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: event with none expected: x=%0d y=%0d button=%0d count=%0d",
                             $time, $signed(got.ev_x), $signed(got.ev_y),
                             got.ev_button, got.ev_count);
            end else begin
                want = expected_clicks.pop_front();
                events_checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: event mismatch: expected x=%0d y=%0d button=%0d count=%0d,",
                                 $time, $signed(want.ev_x), $signed(want.ev_y),
                                 want.ev_button, want.ev_count,
                                 " actual x=%0d y=%0d button=%0d count=%0d",
                                 $signed(got.ev_x), $signed(got.ev_y),
                                 got.ev_button, got.ev_count);
                end
            end
        end
    end

    // queue one item, mirror the level that the stimulus expects
    task automatic put_item(input mcbd_pkg::t_op op, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [BTN_W-1:0] b,
                            input logic l, input logic [TS_W-1:0] ts);
        t_button_sample s;
        s.op = op;
        s.pos_x = x;
        s.pos_y = y;
        s.button = b;
        s.level = l;
        s.time_ms = ts;
        pending_samples.push_back(s);
        if (op == mcbd_pkg::OP_POS || b < NBTN)
            gen_count++;
        if (op == mcbd_pkg::OP_BUTTON && b < NBTN)
            gen_down[b] = l;
    endtask

    task automatic put_pos(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        put_item(mcbd_pkg::OP_POS, x, y, BTN_W'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic put_btn(input logic [BTN_W-1:0] b, input logic l, input logic [TS_W-1:0] ts);
        put_item(mcbd_pkg::OP_BUTTON, POS_W'($urandom), POS_W'($urandom), b, l, ts);
    endtask

    task automatic put_level(input logic [BTN_W-1:0] b, input logic l);
        put_btn(b, l, gen_now);
    endtask

    // time step around a threshold, on both sides of it
    function automatic logic [TS_W-1:0] pick_span(input logic [MS_W-1:0] lim);
        logic [TS_W-1:0] l32;
        l32 = {{(TS_W-MS_W){1'b0}}, lim};
        case ($urandom_range(0, 5))
            0:       pick_span = (lim == '0) ? '0 : l32 - 32'd1;
            1:       pick_span = l32;
            2:       pick_span = l32 + 32'd1;
            3:       pick_span = $urandom_range(0, l32);
            4:       pick_span = $urandom;
            default: pick_span = $urandom_range(0, 3);
        endcase
    endfunction

    // one multi-click run on a random button
    task automatic click_run();
        logic [BTN_W-1:0] b;
        int               presses;
        b = BTN_W'($urandom_range(0, NBTN - 1));
        presses = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        if (gen_down[b]) begin
            gen_now += $urandom_range(1, 50);
            put_level(b, 1'b0);
        end
        repeat (presses) begin
            if ($urandom_range(0, 3) == 0)
                put_pos(POS_W'($urandom), POS_W'($urandom));
            gen_now += $urandom_range(1, 50);
            put_level(b, 1'b1);
            repeat ($urandom_range(0, 2)) begin
                gen_now += pick_span(hold_set);
                put_level(b, 1'b1);
            end
            gen_now += $urandom_range(1, 50);
            put_level(b, 1'b0);
            repeat ($urandom_range(0, 1)) begin
                gen_now += pick_span(gap_set);
                put_level(b, 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            // end the run while held
            gen_now += $urandom_range(1, 50);
            put_level(b, 1'b1);
            gen_now += pick_span(hold_set);
            put_level(b, 1'b1);
        end else begin
            gen_now += pick_span(gap_set);
            put_level(b, 1'b0);
        end
    endtask

    // random phase: mostly click runs, some position updates and noise
    task automatic random_phase(input int target);
        int stop;
        stop = gen_count + target;
        while (gen_count < stop) begin
            case ($urandom_range(0, 19))
                0:       gen_now = $urandom;
                1, 2:    put_pos(POS_W'($urandom), POS_W'($urandom));
                3, 4, 5: put_item(mcbd_pkg::t_op'($urandom_range(0, 1)),
                                  POS_W'($urandom), POS_W'($urandom),
                                  BTN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  ($urandom_range(0, 1) != 0) ? gen_now + $urandom_range(0, 1000)
                                                              : $urandom);
                default: click_run();
            endcase
        end
    endtask

    // wait until all items are taken and all events are in
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_clicks.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write over the configuration channel
    task automatic write_reg(input mcbd_pkg::t_cfg_reg idx, input logic [MS_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == mcbd_pkg::CFG_CLICK_HOLD) begin
            hold_lim = val;
            hold_set = val;
        end else begin
            gap_lim = val;
            gap_set = val;
        end
        cfg_writes++;
    endtask

    task automatic configure(input logic [MS_W-1:0] hold, input logic [MS_W-1:0] gap);
        write_reg(mcbd_pkg::CFG_CLICK_HOLD, hold);
        write_reg(mcbd_pkg::CFG_RELEASE_GAP, gap);
        settings_used++;
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // stimulus and end of run
    initial begin
        foreach (gen_down[k])
            gen_down[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_pace(36, 63);

        // hand-picked cases at the reset setting
        put_pos(16'h8000, 16'h7FFF);
        put_btn(3'd0, 1'b0, 32'd10);        // same level, nothing pending
        put_btn(3'd0, 1'b1, 32'd100);       // press notice
        put_btn(3'd0, 1'b1, 32'd399);       // one short of the hold time
        put_btn(3'd0, 1'b1, 32'd400);       // exactly the hold time
        put_btn(3'd0, 1'b0, 32'd450);       // release edge
        put_btn(3'd0, 1'b0, 32'd800);       // released, count already cleared
        put_pos(16'h7FFF, 16'h8000);
        put_btn(3'd4, 1'b1, 32'd1000);      // double click on the last button
        put_btn(3'd4, 1'b0, 32'd1050);
        put_btn(3'd4, 1'b1, 32'd1100);
        put_btn(3'd4, 1'b0, 32'd1150);
        put_btn(3'd4, 1'b0, 32'd1449);
        put_btn(3'd4, 1'b0, 32'd1450);
        put_btn(3'd5, 1'b1, 32'd2000);      // buttons out of range
        put_btn(3'd7, 1'b1, 32'd2000);
        put_btn(3'd6, 1'b0, $urandom);
        put_pos(16'h0000, 16'h0000);
        put_btn(3'd2, 1'b1, 32'hFFFF_FF00); // hold across the timestamp wrap
        put_btn(3'd2, 1'b1, 32'h0000_0100);
        put_pos(16'hFFFF, 16'hFFFF);
        put_btn(3'd1, 1'b1, 32'hFFFF_FFFF); // release gap across the wrap
        put_btn(3'd1, 1'b0, 32'h0000_0005);
        put_btn(3'd1, 1'b0, 32'h0000_0131);
        gen_now = 32'h0000_0200;
        wait_idle();

        // zero thresholds
        configure(16'h0000, 16'h0000);
        random_phase(220);
        wait_idle();

        // largest thresholds, press count saturation on one button
        set_pace(63, 36);
        configure(16'hFFFF, 16'hFFFF);
        gen_now += 5;
        put_level(3'd3, 1'b0);
        repeat (260) begin
            gen_now += 1;
            put_level(3'd3, 1'b1);
            gen_now += 1;
            put_level(3'd3, 1'b0);
        end
        gen_now += 32'h0000_FFFF;
        put_level(3'd3, 1'b0);
        random_phase(150);
        wait_idle();

        // random moderate thresholds, timestamps near the wrap
        configure(MS_W'($urandom_range(1, 600)), MS_W'($urandom_range(1, 600)));
        gen_now = 32'hFFFF_F000;
        random_phase(220);
        wait_idle();

        // no stalls, mixed extremes
        set_pace(0, 0);
        configure(16'h0000, 16'hFFFF);
        random_phase(220);
        wait_idle();

        configure(16'hFFFF, MS_W'($urandom_range(1, 400)));
        random_phase(220);
        wait_idle();

        $display("run covered %0d input transfers and %0d checked events", items_accepted,
                 events_checked);
        $display("over %0d threshold settings with %0d register writes", settings_used,
                 cfg_writes);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d events outstanding", expected_clicks.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== multi_click_button_detector.f =====
sv/mcbd_pkg.sv
sv/multi_click_button_detector.sv
verif/testbench.sv
